// ===== rtl/fcca_pkg.sv =====
// Shared widths, operation codes and status codes of the cluster chain allocator.
package fcca_pkg;

	localparam int unsigned TABLE_ENTRIES_DEF = 512;

	localparam int unsigned FUNC_W   = 2;
	localparam int unsigned COUNT_W  = 10;
	localparam int unsigned INDEX_W  = 9;
	localparam int unsigned VALUE_W  = 10;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned LEFT_W   = 10;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ALLOC = 2'd0,
		FUNC_FREE  = 2'd1,
		FUNC_READ  = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_SHORT = 2'd2
	} status_t;

endpackage

// ===== rtl/fcca_req_if.sv =====
// Request channel of the allocator: operation, cluster count and start index.
interface fcca_req_if;
	import fcca_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [FUNC_W-1:0]    func;
	logic [COUNT_W-1:0]   cluster_count;
	logic [INDEX_W-1:0]   start_index;

	modport source (output valid, output func, output cluster_count, output start_index,
		input ready);
	modport sink (input valid, input func, input cluster_count, input start_index,
		output ready);
endinterface

// ===== rtl/fcca_rsp_if.sv =====
// Response channel of the allocator: value, status and free entry count.
interface fcca_rsp_if;
	import fcca_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [VALUE_W-1:0]  value;
	logic [STATUS_W-1:0]        status;
	logic [LEFT_W-1:0]          free_left;

	modport source (output valid, output value, output status, output free_left,
		input ready);
	modport sink (input valid, input value, input status, input free_left,
		output ready);
endinterface

// ===== rtl/fat_cluster_chain_allocator_unit.sv =====
// Allocation table unit: the table sits in one synchronous RAM and is walked one entry a cycle.
// Read fetches an entry; free clears the chain; allocate links free entries into a chain.
// Refused, empty and out-of-range requests skip the table; one request is in work at a time.
// Allocate of zero clusters returns the lowest free index; one table entry visited per cycle.
// After arst_n falls, a clearing pass writes TABLE_ENTRIES entries, one a cycle, before
// the first request is taken; the response register holds a finished word while the next runs.
module fat_cluster_chain_allocator_unit #(
	parameter int unsigned TABLE_ENTRIES = fcca_pkg::TABLE_ENTRIES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	fcca_req_if.sink   req,
	fcca_rsp_if.source rsp
);
	import fcca_pkg::*;

	localparam int unsigned AW = $clog2(TABLE_ENTRIES);
	localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
	localparam int unsigned EW = AW + 1;
	localparam int unsigned SW = AW + INDEX_W;

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_ALLOC = 7'b0000100,
		ST_ATAIL = 7'b0001000,
		ST_WALK  = 7'b0010000,
		ST_READ  = 7'b0100000,
		ST_RESP  = 7'b1000000
	} state_t;

	// entry encoding: MSB marks end of chain, all zero is free, else next index
	localparam logic [EW-1:0] ENT_FREE = '0;
	localparam logic [EW-1:0] ENT_END  = {1'b1, {AW{1'b0}}};

	state_t               state_q;
	logic [AW-1:0]        clr_q;
	logic [CW-1:0]        free_total_q;
	logic [CW-1:0]        scan_q;
	logic                 vld_s1;
	logic [AW-1:0]        k_s1;
	logic [EW-1:0]        rd_s1;
	logic                 zero_q;
	logic [COUNT_W-1:0]   count_q;
	logic [COUNT_W-1:0]   linked_q;
	logic [AW-1:0]        prev_q;
	logic [AW-1:0]        first_q;
	logic [AW-1:0]        cur_q;
	logic [COUNT_W-1:0]   left_q;
	logic [VALUE_W-1:0]   res_value_q;
	logic [STATUS_W-1:0]  res_status_q;
	logic                 rsp_valid_q;
	logic [VALUE_W-1:0]   rsp_value_q;
	logic [STATUS_W-1:0]  rsp_status_q;
	logic [LEFT_W-1:0]    rsp_left_q;

	logic [EW-1:0]        fat_mem [TABLE_ENTRIES];

	logic                 mem_we;
	logic [AW-1:0]        mem_wa;
	logic [EW-1:0]        mem_wd;
	logic                 mem_re;
	logic [AW-1:0]        mem_ra;

	logic [SW-1:0]        start_w;
	logic                 start_ok;
	logic [AW-1:0]        start_addr;
	logic                 req_acc;
	logic                 alloc_hit;
	logic                 alloc_last;
	logic [COUNT_W-1:0]   left_dec;
	logic                 walk_go;
	logic                 rsp_load;

	assign start_w    = SW'(req.start_index);
	assign start_ok   = start_w < SW'(TABLE_ENTRIES);
	assign start_addr = start_w[AW-1:0];
	assign req.ready  = (state_q == ST_IDLE);
	assign req_acc    = req.valid && req.ready;

	assign alloc_hit  = (state_q == ST_ALLOC) && vld_s1 && (rd_s1 == ENT_FREE);
	assign alloc_last = alloc_hit && !zero_q && ((linked_q + COUNT_W'(1)) == count_q);
	assign left_dec   = left_q - COUNT_W'(1);
	// keep walking while the entry is linked onward and clusters remain
	assign walk_go    = (rd_s1 != ENT_FREE) && !rd_s1[AW] && (left_dec != '0);
	assign rsp_load   = (state_q == ST_RESP) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = ENT_FREE;
		mem_re = 1'b0;
		mem_ra = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
			end
			ST_IDLE: begin
				if (req_acc && start_ok && req.cluster_count != '0 &&
					req.func == FUNC_FREE) begin
					mem_re = 1'b1;
					mem_ra = start_addr;
				end
				if (req_acc && start_ok && req.func == FUNC_READ) begin
					mem_re = 1'b1;
					mem_ra = start_addr;
				end
			end
			ST_ALLOC: begin
				mem_re = scan_q < CW'(TABLE_ENTRIES);
				mem_ra = scan_q[AW-1:0];
				// link the previous cluster to the one just found
				if (alloc_hit && !zero_q && linked_q != '0) begin
					mem_we = 1'b1;
					mem_wa = prev_q;
					mem_wd = {1'b0, k_s1};
				end
			end
			ST_ATAIL: begin
				mem_we = 1'b1;
				mem_wa = prev_q;
				mem_wd = ENT_END;
			end
			ST_WALK: begin
				if (rd_s1 != ENT_FREE) begin
					mem_we = 1'b1;
					mem_wa = cur_q;
				end
				if (walk_go) begin
					mem_re = 1'b1;
					mem_ra = rd_s1[AW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			fat_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_s1 <= fat_mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			free_total_q <= CW'(TABLE_ENTRIES);
			vld_s1       <= 1'b0;
			rsp_valid_q  <= 1'b0;
			scan_q       <= '0;
			k_s1         <= '0;
			zero_q       <= 1'b0;
			count_q      <= '0;
			linked_q     <= '0;
			prev_q       <= '0;
			first_q      <= '0;
			cur_q        <= '0;
			left_q       <= '0;
			res_value_q  <= '0;
			res_status_q <= STAT_OK;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			vld_s1 <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(TABLE_ENTRIES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_acc) begin
						res_value_q  <= '0;
						res_status_q <= STAT_OK;
						scan_q       <= '0;
						linked_q     <= '0;
						count_q      <= req.cluster_count;
						zero_q       <= (req.cluster_count == '0);
						cur_q        <= start_addr;
						left_q       <= req.cluster_count;
						state_q      <= ST_RESP;
						case (req.func)
							FUNC_ALLOC: begin
								if (req.cluster_count == '0) begin
									if (free_total_q == '0) begin
										res_value_q  <= '1;
										res_status_q <= STAT_FULL;
									end else begin
										state_q <= ST_ALLOC;
									end
								end else if (32'(req.cluster_count) > 32'(free_total_q)) begin
									res_status_q <= STAT_FULL;
								end else begin
									state_q <= ST_ALLOC;
								end
							end
							FUNC_FREE: begin
								if (req.cluster_count != '0) begin
									if (start_ok) begin
										state_q <= ST_WALK;
									end else begin
										res_status_q <= STAT_SHORT;
									end
								end
							end
							FUNC_READ: begin
								if (start_ok) begin
									state_q <= ST_READ;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_ALLOC: begin
					if (scan_q < CW'(TABLE_ENTRIES)) begin
						scan_q <= scan_q + CW'(1);
						vld_s1 <= 1'b1;
						k_s1   <= scan_q[AW-1:0];
					end
					if (alloc_hit) begin
						if (zero_q) begin
							res_value_q <= VALUE_W'(k_s1);
							state_q     <= ST_RESP;
							vld_s1      <= 1'b0;
						end else begin
							if (linked_q == '0) begin
								first_q <= k_s1;
							end
							prev_q       <= k_s1;
							linked_q     <= linked_q + COUNT_W'(1);
							free_total_q <= free_total_q - CW'(1);
							if (alloc_last) begin
								state_q <= ST_ATAIL;
								vld_s1  <= 1'b0;
							end
						end
					end
				end
				ST_ATAIL: begin
					res_value_q <= VALUE_W'(first_q);
					state_q     <= ST_RESP;
				end
				ST_WALK: begin
					if (rd_s1 == ENT_FREE) begin
						res_status_q <= STAT_SHORT;
						state_q      <= ST_RESP;
					end else begin
						free_total_q <= free_total_q + CW'(1);
						left_q       <= left_dec;
						cur_q        <= rd_s1[AW-1:0];
						if (rd_s1[AW] && left_dec != '0) begin
							res_status_q <= STAT_SHORT;
						end
						if (!walk_go) begin
							state_q <= ST_RESP;
						end
					end
				end
				ST_READ: begin
					res_value_q <= rd_s1[AW] ? '1 : VALUE_W'(rd_s1[AW-1:0]);
					state_q     <= ST_RESP;
				end
				ST_RESP: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// response word register, no reset needed on payload
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_value_q  <= res_value_q;
			rsp_status_q <= res_status_q;
			rsp_left_q   <= LEFT_W'(free_total_q);
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.value     = $signed(rsp_value_q);
	assign rsp.status    = rsp_status_q;
	assign rsp.free_left = rsp_left_q;

`ifndef SYNTHESIS
	a_free_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_total_q <= CW'(TABLE_ENTRIES))
		else $error("free entry count exceeds table size");

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && mem_re |-> mem_wa != mem_ra)
		else $error("table read and write hit the same entry");

	a_zero_alloc_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ALLOC && zero_q |-> !mem_we)
		else $error("zero-count allocate wrote the table");

	a_tail_then_resp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ATAIL |=> state_q == ST_RESP)
		else $error("chain tail write not followed by response");

	a_rsp_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == ST_RESP)
		else $error("response word raised outside response state");
`endif

endmodule
